/* design/fapp_pkg.sv */
// ----------------------------------------------------------------------------
// fapp_pkg
// Shared types and constants for the framed attitude packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fapp_pkg;

    // Frame header bytes, in order of arrival.
    localparam logic [7:0] HDR0 = 8'h44;
    localparam logic [7:0] HDR1 = 8'h49;
    localparam logic [7:0] HDR2 = 8'h59;
    localparam logic [7:0] HDR3 = 8'h64;

    // Register reset values.
    localparam logic [7:0] MAX_PAYLOAD_LENGTH_RESET  = 8'd22;
    localparam logic [7:0] ATTITUDE_MESSAGE_ID_RESET = 8'h02;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LENGTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTITUDE_MESSAGE_ID = 8'd1;

    // Number of payload bytes captured for roll, pitch and yaw.
    localparam int unsigned HEAD_BYTES = 6;
    localparam int unsigned HEAD_IDX_W = $clog2(HEAD_BYTES);
    localparam logic [7:0]  HEAD_BYTES_B = 8'(HEAD_BYTES);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_HDR2    = 4'd2,
        PH_HDR3    = 4'd3,
        PH_LENGTH  = 4'd4,
        PH_ID      = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_SUM_A   = 4'd7,
        PH_SUM_B   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ST_ATT_OK     = 2'd0,
        ST_CSUM_ERR   = 2'd1,
        ST_UNKNOWN_ID = 2'd2,
        ST_LEN_ERR    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] max_payload_length;
        logic [7:0] attitude_message_id;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         frame_id;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [7:0]         checksum_error_total;
        logic [7:0]         length_error_total;
        logic [15:0]        good_frame_total;
    } result_t;

endpackage

`default_nettype wire

/* design/fapp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fapp_cfg_regs
// Configuration register file: maximum payload length and attitude id.
// ----------------------------------------------------------------------------
`default_nettype none

module fapp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [fapp_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [7:0]                      wr_data,
    output fapp_pkg::cfg_t                       cfg
);
    import fapp_pkg::*;

    cfg_t cfg_reg;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_length  <= MAX_PAYLOAD_LENGTH_RESET;
            cfg_reg.attitude_message_id <= ATTITUDE_MESSAGE_ID_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_MAX_PAYLOAD_LENGTH)
            begin
                cfg_reg.max_payload_length <= wr_data;
            end
            else if (wr_index == REG_ATTITUDE_MESSAGE_ID)
            begin
                cfg_reg.attitude_message_id <= wr_data;
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/fapp_parser.sv */
// ----------------------------------------------------------------------------
// fapp_parser
// Frame state machine, Fletcher sums, payload capture and counters. One byte
// is processed per step; the result for a finished frame is given combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module fapp_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    byte_in,
    input  wire fapp_pkg::cfg_t cfg,
    output logic               res_valid,
    output fapp_pkg::result_t  res
);
    import fapp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  seen_reg,   seen_next;
    logic [7:0]  sum_a_reg,  sum_a_next;
    logic [7:0]  sum_b_reg,  sum_b_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [7:0]  head_reg [HEAD_BYTES];
    logic [7:0]  head_next [HEAD_BYTES];
    logic [15:0] roll_reg,  roll_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [15:0] yaw_reg,   yaw_next;
    logic [7:0]  csum_err_reg, csum_err_next;
    logic [7:0]  len_err_reg,  len_err_next;
    logic [15:0] good_reg,     good_next;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [7:0]  seen_inc;
    status_t     status_sel;
    logic [7:0]  id_sel;

    // Fletcher step on the incoming byte.
    assign add_a    = sum_a_reg + byte_in;
    assign add_b    = sum_b_reg + add_a;
    assign seen_inc = (seen_reg != 8'hFF) ? seen_reg + 8'd1 : seen_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        exp_len_next  = exp_len_reg;
        seen_next     = seen_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        rx_sum_a_next = rx_sum_a_reg;
        cur_id_next   = cur_id_reg;
        head_next     = head_reg;
        roll_next     = roll_reg;
        pitch_next    = pitch_reg;
        yaw_next      = yaw_reg;
        csum_err_next = csum_err_reg;
        len_err_next  = len_err_reg;
        good_next     = good_reg;
        res_valid     = 1'b0;
        status_sel    = ST_ATT_OK;
        id_sel        = cur_id_reg;

        unique case (phase_reg)
            PH_HDR1:
            begin
                phase_next = (byte_in == HDR1) ? PH_HDR2 : PH_HUNT;
            end
            PH_HDR2:
            begin
                phase_next = (byte_in == HDR2) ? PH_HDR3 : PH_HUNT;
            end
            PH_HDR3:
            begin
                phase_next = (byte_in == HDR3) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH:
            begin
                exp_len_next = byte_in;
                if (byte_in > cfg.max_payload_length)
                begin
                    // Oversize length: abort before any id is read.
                    len_err_next = len_err_reg + 8'd1;
                    phase_next   = PH_HUNT;
                    seen_next    = 8'd0;
                    sum_a_next   = 8'd0;
                    sum_b_next   = 8'd0;
                    res_valid    = 1'b1;
                    status_sel   = ST_LEN_ERR;
                    id_sel       = 8'd0;
                end
                else
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_ID;
                end
            end
            PH_ID:
            begin
                cur_id_next = byte_in;
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                for (int i = 0; i < HEAD_BYTES; i++)
                begin
                    if (seen_reg < HEAD_BYTES_B && seen_reg[HEAD_IDX_W-1:0] == HEAD_IDX_W'(i))
                    begin
                        head_next[i] = byte_in;
                    end
                end
                sum_a_next = add_a;
                sum_b_next = add_b;
                seen_next  = seen_inc;
                // A zero length still takes one payload byte.
                if (seen_inc >= exp_len_reg)
                begin
                    phase_next = PH_SUM_A;
                end
            end
            PH_SUM_A:
            begin
                rx_sum_a_next = byte_in;
                phase_next    = PH_SUM_B;
            end
            PH_SUM_B:
            begin
                if (sum_a_reg == rx_sum_a_reg && sum_b_reg == byte_in)
                begin
                    if (cur_id_reg == cfg.attitude_message_id)
                    begin
                        roll_next  = {head_reg[1], head_reg[0]};
                        pitch_next = {head_reg[3], head_reg[2]};
                        yaw_next   = {head_reg[5], head_reg[4]};
                        good_next  = good_reg + 16'd1;
                        status_sel = ST_ATT_OK;
                    end
                    else
                    begin
                        status_sel = ST_UNKNOWN_ID;
                    end
                end
                else
                begin
                    csum_err_next = csum_err_reg + 8'd1;
                    status_sel    = ST_CSUM_ERR;
                end
                phase_next = PH_HUNT;
                seen_next  = 8'd0;
                sum_a_next = 8'd0;
                sum_b_next = 8'd0;
                res_valid  = 1'b1;
            end
            default:
            begin
                // Hunting; unused phase codes behave the same way.
                phase_next = (byte_in == HDR0) ? PH_HDR1 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            exp_len_reg  <= 8'd0;
            seen_reg     <= 8'd0;
            sum_a_reg    <= 8'd0;
            sum_b_reg    <= 8'd0;
            rx_sum_a_reg <= 8'd0;
            cur_id_reg   <= 8'd0;
            for (int i = 0; i < HEAD_BYTES; i++)
            begin
                head_reg[i] <= 8'd0;
            end
            roll_reg     <= 16'd0;
            pitch_reg    <= 16'd0;
            yaw_reg      <= 16'd0;
            csum_err_reg <= 8'd0;
            len_err_reg  <= 8'd0;
            good_reg     <= 16'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            exp_len_reg  <= exp_len_next;
            seen_reg     <= seen_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            rx_sum_a_reg <= rx_sum_a_next;
            cur_id_reg   <= cur_id_next;
            head_reg     <= head_next;
            roll_reg     <= roll_next;
            pitch_reg    <= pitch_next;
            yaw_reg      <= yaw_next;
            csum_err_reg <= csum_err_next;
            len_err_reg  <= len_err_next;
            good_reg     <= good_next;
        end
    end

    // The result carries the state as it stands after this byte.
    always_comb
    begin
        res.status               = status_sel;
        res.frame_id             = id_sel;
        res.roll                 = roll_next;
        res.pitch                = pitch_next;
        res.yaw                  = yaw_next;
        res.checksum_error_total = csum_err_next;
        res.length_error_total   = len_err_next;
        res.good_frame_total     = good_next;
    end

endmodule

`default_nettype wire

/* design/framed_attitude_packet_parser_top.sv */
// ----------------------------------------------------------------------------
// framed_attitude_packet_parser_top
// Byte-stream frame parser that extracts roll, pitch and yaw from attitude
// frames and reports frame status with wrapping error and frame counters.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer on the input channel and
// sustains one byte per clock cycle while the output side does not stall. A
// byte first lands in an input register; the parser state machine consumes
// it whenever the output register is empty or drains and, when the byte
// ends or aborts a frame, the result goes into the output register. Bytes
// that do not end a frame produce no output transfer. Frames are the four
// header bytes 0x44 0x49 0x59 0x64, a length byte, a message id, the payload
// (a length of zero still takes one payload byte), and two checksum bytes of
// an 8-bit Fletcher sum over length, id and payload. A length above
// max_payload_length gives a length-error result right away with frame_id 0.
// Roll, pitch and yaw are signed little-endian words from payload bytes 0..5
// and hold their value from the last good attitude frame. The input register
// frees up while a result waits for the output side, so one further byte is
// taken during an output stall; beyond that the input channel waits. The
// configuration port is always ready and is meant to be written only while
// no frame result is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_attitude_packet_parser_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      rx_byte,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           status,
    output logic [7:0]                           frame_id,
    output logic signed [15:0]                   roll,
    output logic signed [15:0]                   pitch,
    output logic signed [15:0]                   yaw,
    output logic [7:0]                           checksum_error_total,
    output logic [7:0]                           length_error_total,
    output logic [15:0]                          good_frame_total,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fapp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import fapp_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;

    // The configuration port takes a write in every cycle.
    assign cfg_ready = 1'b1;

    fapp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The pipeline moves whenever the output register is empty or drains.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    fapp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid            = out_valid_reg;
    assign status               = out_reg.status;
    assign frame_id             = out_reg.frame_id;
    assign roll                 = out_reg.roll;
    assign pitch                = out_reg.pitch;
    assign yaw                  = out_reg.yaw;
    assign checksum_error_total = out_reg.checksum_error_total;
    assign length_error_total   = out_reg.length_error_total;
    assign good_frame_total     = out_reg.good_frame_total;

    // A waiting result must stop the parser from consuming another byte.
    a_stall_holds_parser: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !step)
        else $error("parser stepped while a result was stalled");

    // A result produced by the parser must show up on the output next cycle.
    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> out_valid_reg)
        else $error("parser result was lost");

    // A length abort happens before an id is read, so it reports id zero.
    a_len_err_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.status == ST_LEN_ERR) |-> (res.frame_id == 8'd0))
        else $error("length error reported a nonzero frame id");

endmodule

`default_nettype wire

/* test/fapp_checker.sv */
// ----------------------------------------------------------------------------
// fapp_checker
// Watches the byte, result and register channels of the frame parser,
// predicts every frame result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module fapp_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [7:0]               rx_byte,

    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [1:0]               status,
    input  wire logic [7:0]               frame_id,
    input  wire logic signed [15:0]       roll,
    input  wire logic signed [15:0]       pitch,
    input  wire logic signed [15:0]       yaw,
    input  wire logic [7:0]               checksum_error_total,
    input  wire logic [7:0]               length_error_total,
    input  wire logic [15:0]              good_frame_total,

    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [fapp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]               cfg_data,

    output int                            error_count,
    output int                            frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fapp_pkg::*;

    // Private copy of the parser state and its registers.
    cfg_t               settings;
    phase_t             phase;
    logic [7:0]         frame_length;
    logic [7:0]         payload_count;
    logic [7:0]         sum_a;
    logic [7:0]         sum_b;
    logic [7:0]         sent_sum_a;
    logic [7:0]         message_id;
    logic [7:0]         head [HEAD_BYTES];
    logic signed [15:0] roll_q;
    logic signed [15:0] pitch_q;
    logic signed [15:0] yaw_q;
    logic [7:0]         csum_errs;
    logic [7:0]         len_errs;
    logic [15:0]        good_count;

    result_t expected_frames [$];

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic clear_parser();
        settings.max_payload_length  = MAX_PAYLOAD_LENGTH_RESET;
        settings.attitude_message_id = ATTITUDE_MESSAGE_ID_RESET;
        phase         = PH_HUNT;
        frame_length  = '0;
        payload_count = '0;
        sum_a         = '0;
        sum_b         = '0;
        sent_sum_a    = '0;
        message_id    = '0;
        for (int i = 0; i < HEAD_BYTES; i++)
            head[i] = '0;
        roll_q     = '0;
        pitch_q    = '0;
        yaw_q      = '0;
        csum_errs  = '0;
        len_errs   = '0;
        good_count = '0;
    endtask

    task automatic restart_hunt();
        phase         = PH_HUNT;
        payload_count = '0;
        sum_a         = '0;
        sum_b         = '0;
    endtask

    task automatic accumulate(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    task automatic push_result(input status_t st, input logic [7:0] id);
        result_t r;
        r.status               = st;
        r.frame_id             = id;
        r.roll                 = roll_q;
        r.pitch                = pitch_q;
        r.yaw                  = yaw_q;
        r.checksum_error_total = csum_errs;
        r.length_error_total   = len_errs;
        r.good_frame_total     = good_count;
        expected_frames.push_back(r);
    endtask

    // Advances the parser by one byte and queues a result when a frame ends
    // or is aborted on its length byte.
    task automatic parse_byte(input logic [7:0] b);
        status_t st;
        case (phase)
            PH_HDR1: phase = (b == HDR1) ? PH_HDR2 : PH_HUNT;
            PH_HDR2: phase = (b == HDR2) ? PH_HDR3 : PH_HUNT;
            PH_HDR3: phase = (b == HDR3) ? PH_LENGTH : PH_HUNT;
            PH_LENGTH: begin
                frame_length = b;
                accumulate(b);
                if (b > settings.max_payload_length) begin
                    len_errs = len_errs + 8'd1;
                    restart_hunt();
                    push_result(ST_LEN_ERR, 8'd0);
                end else begin
                    phase = PH_ID;
                end
            end
            PH_ID: begin
                message_id = b;
                accumulate(b);
                phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (payload_count < HEAD_BYTES_B)
                    head[payload_count[HEAD_IDX_W-1:0]] = b;
                accumulate(b);
                if (payload_count != 8'hFF)
                    payload_count = payload_count + 8'd1;
                if (payload_count >= frame_length)
                    phase = PH_SUM_A;
            end
            PH_SUM_A: begin
                sent_sum_a = b;
                phase = PH_SUM_B;
            end
            PH_SUM_B: begin
                if (sum_a == sent_sum_a && sum_b == b) begin
                    if (message_id == settings.attitude_message_id) begin
                        roll_q     = {head[1], head[0]};
                        pitch_q    = {head[3], head[2]};
                        yaw_q      = {head[5], head[4]};
                        good_count = good_count + 16'd1;
                        st = ST_ATT_OK;
                    end else begin
                        st = ST_UNKNOWN_ID;
                    end
                end else begin
                    csum_errs = csum_errs + 8'd1;
                    st = ST_CSUM_ERR;
                end
                restart_hunt();
                push_result(st, message_id);
            end
            default: phase = (b == HDR0) ? PH_HDR1 : PH_HUNT;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            clear_parser();
            expected_frames.delete();
            error_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_PAYLOAD_LENGTH:  settings.max_payload_length  = cfg_data;
                    REG_ATTITUDE_MESSAGE_ID: settings.attitude_message_id = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                parse_byte(rx_byte);
            if (out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    report_error("result transfer with no frame expected");
                end else begin
                    want = expected_frames.pop_front();
                    check_field("status", 16'(status), 16'(want.status));
                    check_field("frame_id", 16'(frame_id), 16'(want.frame_id));
                    check_field("roll", roll, want.roll);
                    check_field("pitch", pitch, want.pitch);
                    check_field("yaw", yaw, want.yaw);
                    check_field("checksum_error_total", 16'(checksum_error_total),
                                16'(want.checksum_error_total));
                    check_field("length_error_total", 16'(length_error_total),
                                16'(want.length_error_total));
                    check_field("good_frame_total", good_frame_total,
                                want.good_frame_total);
                end
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the framed attitude packet parser.
// ----------------------------------------------------------------------------
// A short directed sequence covers the header hunt, zero and oversize
// lengths, unknown ids, checksum failures and the extreme attitude words.
// Random traffic follows in four register settings, mostly well-formed
// frames with random content mixed with broken headers, oversize lengths
// and line noise. The byte sender works in bursts and the result side
// stalls on its own pattern. A separate checker predicts and compares every
// result transfer; this module only drives the block and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fapp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300_000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              rx_byte = 8'h00;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              status;
    logic [7:0]              frame_id;
    logic signed [15:0]      roll;
    logic signed [15:0]      pitch;
    logic signed [15:0]      yaw;
    logic [7:0]              checksum_error_total;
    logic [7:0]              length_error_total;
    logic [15:0]             good_frame_total;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [7:0]              cfg_data = 8'h00;

    int                      error_count;
    int                      frames_pending;

    // Register values currently in force, so that stimulus can aim at them.
    logic [7:0]              cur_max = MAX_PAYLOAD_LENGTH_RESET;
    logic [7:0]              cur_id  = ATTITUDE_MESSAGE_ID_RESET;

    int unsigned             bytes_sent = 0;
    int unsigned             burst_left = 0;
    int unsigned             cycle_count = 0;
    logic [7:0]              payload_bytes [$];

    framed_attitude_packet_parser_top uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .frame_id             (frame_id),
        .roll                 (roll),
        .pitch                (pitch),
        .yaw                  (yaw),
        .checksum_error_total (checksum_error_total),
        .length_error_total   (length_error_total),
        .good_frame_total     (good_frame_total),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    fapp_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .frame_id             (frame_id),
        .roll                 (roll),
        .pitch                (pitch),
        .yaw                  (yaw),
        .checksum_error_total (checksum_error_total),
        .length_error_total   (length_error_total),
        .good_frame_total     (good_frame_total),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .error_count          (error_count),
        .frames_pending       (frames_pending)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs on either handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The result side runs through segments of different stall density,
    // including segments where it never stalls. Within a segment it stalls
    // for short random runs so that backpressure lands on every phase.
    int unsigned stall_left = 0;
    int unsigned stall_percent = 0;
    int unsigned segment_left = 0;

    always @(negedge clk) begin
        if (segment_left == 0) begin
            segment_left = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0:       stall_percent = 0;
                1:       stall_percent = 15;
                2:       stall_percent = 40;
                default: stall_percent = 75;
            endcase
        end
        segment_left--;
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_percent) begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // One byte transfer. The sender runs in bursts; when a burst is used up
    // it drops valid for a random gap first. Every call starts and ends at a
    // falling edge, and valid stays high from one byte to the next within a
    // burst, so it is never lowered and raised in the same step.
    task automatic send_byte(input logic [7:0] value);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            // Now and then a long burst gives a stretch without any gaps.
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(150, 300);
            else
                burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Stops the sender and waits until every expected result has been
    // transferred, then lets the pipeline drain, since a trailing byte that
    // ends no frame may still be in flight.
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (frames_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers back to back; valid stays high between the two
    // transfers and drops only after the second.
    task automatic configure(input logic [7:0] max_len, input logic [7:0] att_id);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD_LENGTH;
        cfg_data  <= max_len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_index <= REG_ATTITUDE_MESSAGE_ID;
        cfg_data  <= att_id;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        cur_max = max_len;
        cur_id  = att_id;
    endtask

    task automatic send_header();
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(HDR3);
    endtask

    // Sends a whole frame around the body held in payload_bytes. The two
    // check bytes are a Fletcher sum over length, id and body; when asked,
    // one of them is spoiled.
    task automatic send_frame(input logic [7:0] length, input logic [7:0] id,
                              input bit corrupt);
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] flip;
        sa = length;
        sb = length;
        sa = sa + id;
        sb = sb + sa;
        foreach (payload_bytes[i]) begin
            sa = sa + payload_bytes[i];
            sb = sb + sa;
        end
        if (corrupt) begin
            flip = $urandom_range(1, 255);
            if ($urandom_range(0, 1) == 0)
                sa = sa ^ flip;
            else
                sb = sb ^ flip;
        end
        send_header();
        send_byte(length);
        send_byte(id);
        foreach (payload_bytes[i])
            send_byte(payload_bytes[i]);
        send_byte(sa);
        send_byte(sb);
    endtask

    // Random body bytes, with the sign and range extremes mixed in often so
    // that the attitude words hit their corners.
    function automatic logic [7:0] body_byte();
        logic [7:0] pick;
        pick = $urandom_range(0, 255);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       pick = 8'h00;
                1:       pick = 8'hFF;
                2:       pick = 8'h80;
                default: pick = 8'h7F;
            endcase
        end
        return pick;
    endfunction

    // Builds a random body for a frame of the given length. A length of zero
    // still carries one body byte.
    task automatic fill_body(input int unsigned length);
        int unsigned count;
        count = (length == 0) ? 1 : length;
        payload_bytes.delete();
        repeat (count) payload_bytes.push_back(body_byte());
    endtask

    // A well-formed frame with random content: mostly short lengths, the
    // attitude id more often than not, and a good checksum most of the time.
    task automatic random_frame();
        int unsigned cap;
        int unsigned length;
        logic [7:0]  id;
        if ($urandom_range(0, 99) == 0) begin
            length = cur_max;
        end else if ($urandom_range(0, 9) < 7) begin
            cap    = (cur_max < 8) ? cur_max : 8;
            length = $urandom_range(0, cap);
        end else begin
            cap    = (cur_max < 40) ? cur_max : 40;
            length = $urandom_range(0, cap);
        end
        id = ($urandom_range(0, 9) < 6) ? cur_id : 8'($urandom_range(0, 255));
        fill_body(length);
        send_frame(8'(length), id, $urandom_range(0, 4) == 0);
    endtask

    // Random traffic until the given number of byte transfers has gone out.
    task automatic run_random(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned k;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                random_frame();
            end else if (pick < 80 && cur_max != 8'hFF) begin
                // Length above the limit aborts the frame at once.
                send_header();
                send_byte(8'($urandom_range(cur_max + 1, 255)));
            end else if (pick < 90) begin
                // Header cut short by a stray byte.
                k = $urandom_range(1, 3);
                send_byte(HDR0);
                if (k > 1) send_byte(HDR1);
                if (k > 2) send_byte(HDR2);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        // Reset is released on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the registers at their reset values.

        // Attitude frame carrying the most negative roll, the most positive
        // pitch and a yaw of minus one.
        payload_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF};
        send_frame(8'd6, cur_id, 1'b0);

        // Zero length still takes one body byte; only the low roll byte is
        // replaced and the other head bytes keep their earlier values.
        payload_bytes = '{8'h5A};
        send_frame(8'd0, cur_id, 1'b0);

        // A good checksum on an id that carries no attitude.
        payload_bytes = '{8'h11, 8'h22};
        send_frame(8'd2, 8'h03, 1'b0);

        // A spoiled checksum on an attitude frame.
        payload_bytes = '{8'hC3};
        send_frame(8'd1, cur_id, 1'b1);

        // Length one past the limit, then the largest length byte.
        send_header();
        send_byte(cur_max + 8'd1);
        send_header();
        send_byte(8'hFF);

        // A repeated first header byte breaks the header and is not taken
        // as a new start, so the rest of that header is ignored.
        send_byte(HDR0);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(HDR3);
        // Header broken on its last byte.
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(8'h00);

        // Random part in four register settings. Each switch waits until the
        // block has nothing outstanding.
        run_random(220);
        wait_idle();
        configure(8'd0, 8'd0);
        run_random(200);
        wait_idle();
        configure(8'hFF, 8'hFF);
        run_random(240);
        wait_idle();
        configure(8'($urandom_range(6, 40)), 8'($urandom_range(0, 255)));
        run_random(240);

        // Drain and give the verdict.
        wait_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
